>>> hw/rtl/riss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Types and constants for the RTSP interleaved stream splitter.
// No dependencies.
package riss_pkg;

  typedef enum logic [1:0] {
    PhBoundary = 2'd0,
    PhHeader   = 2'd1,
    PhPayload  = 2'd2,
    PhRequest  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindPayload = 2'd1,
    KindText    = 2'd2
  } unit_kind_e;

  // Configuration register indexes
  localparam logic CfgMagic = 1'b0;
  localparam logic CfgLimit = 1'b1;

  localparam logic [7:0]  MagicReset = 8'd36;
  localparam int unsigned LimitReset = 2097152;
  localparam int unsigned LimitMin   = 4;
  localparam int          LimitW     = 22;

  localparam logic [7:0] ChCr = 8'd13;
  localparam logic [7:0] ChLf = 8'd10;

endpackage
`default_nettype wire

>>> hw/rtl/rtsp_interleaved_stream_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// RTSP interleaved stream splitter: tags each byte of an RTSP-over-TCP stream.
// Depends on riss_pkg.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+---------------------------------
//  data    | in        | data_valid_i / data_stall_o  | data_byte_i
//  out     | out       | out_valid_o / out_stall_i    | out_byte_o, unit_kind_o, ...
//  cfg     | in        | cfg_we_i                     | cfg_idx_i, cfg_wdata_i
//
// One byte per cycle sustained while the output is not stalled; a transferred byte
// passes the input register, then the result register. The splitter state is
// updated as a byte moves from the input register into the result register.
// rst_ni resets the state and the config registers and clears both valid flags.
// A stalled result holds; an empty input register still takes one more byte, then
// data_stall_o rises until the result is taken.
module rtsp_interleaved_stream_splitter #(
  parameter int unsigned REQUEST_BUFFER_BYTES = 2097152
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // configuration
  input  wire                        cfg_we_i,
  input  wire                        cfg_idx_i,
  input  wire [riss_pkg::LimitW-1:0] cfg_wdata_i,
  // byte input
  input  wire                        data_valid_i,
  output logic                       data_stall_o,
  input  wire [7:0]                  data_byte_i,
  // tagged byte output
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic [1:0]                 unit_kind_o,
  output logic [7:0]                 channel_o,
  output logic [15:0]                payload_length_o,
  output logic                       unit_first_o,
  output logic                       unit_last_o,
  output logic                       overflow_o
);
  import riss_pkg::*;

  // Request byte counter covers the whole buffer size.
  localparam int CntW = $clog2(REQUEST_BUFFER_BYTES + 1);
  // Compare width wide enough for both the register and the buffer size.
  localparam int CmpW = (CntW > LimitW) ? CntW : LimitW;
  localparam int unsigned LimRstVal =
      (LimitReset > REQUEST_BUFFER_BYTES) ? REQUEST_BUFFER_BYTES : LimitReset;
  localparam logic [CntW-1:0] LimRst = CntW'(LimRstVal);
  localparam logic [CmpW-1:0] BufMax = CmpW'(REQUEST_BUFFER_BYTES);
  localparam logic [CmpW-1:0] LimLo  = CmpW'(LimitMin);

  // Config registers; the limit is kept already clamped.
  logic [7:0]      magic_q;
  logic [CntW-1:0] limit_q;
  logic [CmpW-1:0] wdata_ext;
  logic [CntW-1:0] limit_clamped;

  assign wdata_ext = CmpW'(cfg_wdata_i);

  always_comb begin
    if (wdata_ext > BufMax) begin
      limit_clamped = CntW'(BufMax);
    end else if (wdata_ext < LimLo) begin
      limit_clamped = CntW'(LimLo);
    end else begin
      limit_clamped = CntW'(wdata_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= MagicReset;
      limit_q <= LimRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMagic: magic_q <= cfg_wdata_i[7:0];
        CfgLimit: limit_q <= limit_clamped;
        default:  magic_q <= magic_q;
      endcase
    end
  end

  // Input register and handshake.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;   // result register can load this cycle
  logic       step;

  assign advance      = !out_valid_o || !out_stall_i;
  assign step         = in_valid_q && advance;
  assign data_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (data_valid_i && !data_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_valid_i && !data_stall_o) begin
      in_byte_q <= data_byte_i;
    end
  end

  // Splitter state.
  phase_e          phase_q, phase_d;
  logic [1:0]      hidx_q, hidx_d;
  logic [7:0]      chan_q, chan_d;
  logic [15:0]     flen_q, flen_d;
  logic [15:0]     remain_q, remain_d;
  logic [1:0]      term_q, term_d;
  logic [CntW-1:0] rcnt_q, rcnt_d;

  // Result of the current byte.
  unit_kind_e kind_d;
  logic [7:0]  ochan_d;
  logic [15:0] oplen_d;
  logic        first_d, last_d, ovf_d;

  always_comb begin
    logic            text;
    logic            done;
    logic [1:0]      term_cur;
    logic [CntW-1:0] cnt_cur;
    logic [CntW-1:0] count;
    logic [15:0]     rem_dec;

    text     = 1'b0;
    done     = 1'b0;
    term_cur = term_q;
    cnt_cur  = rcnt_q;
    count    = '0;
    rem_dec  = remain_q - 16'd1;

    phase_d  = phase_q;
    hidx_d   = hidx_q;
    chan_d   = chan_q;
    flen_d   = flen_q;
    remain_d = remain_q;
    term_d   = term_q;
    rcnt_d   = rcnt_q;

    kind_d  = KindHeader;
    ochan_d = 8'd0;
    oplen_d = 16'd0;
    first_d = 1'b0;
    last_d  = 1'b0;
    ovf_d   = 1'b0;

    case (phase_q)
      PhBoundary: begin
        first_d = 1'b1;
        if (in_byte_q == magic_q) begin
          chan_d  = 8'd0;
          flen_d  = 16'd0;
          hidx_d  = 2'd1;
          phase_d = PhHeader;
        end else begin
          // Open a text request from a clean match and count.
          text     = 1'b1;
          term_cur = 2'd0;
          cnt_cur  = '0;
        end
      end
      PhHeader: begin
        case (hidx_q)
          2'd1:    chan_d = in_byte_q;
          2'd2:    flen_d = {in_byte_q, 8'd0};
          default: flen_d = {flen_q[15:8], in_byte_q};
        endcase
        ochan_d = chan_d;
        if (hidx_q == 2'd3 || hidx_q == 2'd0) begin
          oplen_d = flen_d;
          hidx_d  = 2'd0;
          if (flen_d == 16'd0) begin
            // Zero length frame ends on its last header byte.
            last_d  = 1'b1;
            phase_d = PhBoundary;
          end else begin
            remain_d = flen_d;
            phase_d  = PhPayload;
          end
        end else begin
          hidx_d = hidx_q + 2'd1;
        end
      end
      PhPayload: begin
        kind_d   = KindPayload;
        ochan_d  = chan_q;
        oplen_d  = flen_q;
        remain_d = rem_dec;
        if (rem_dec == 16'd0) begin
          last_d  = 1'b1;
          phase_d = PhBoundary;
        end
      end
      default: begin
        text = 1'b1;
      end
    endcase

    if (text) begin
      kind_d = KindText;
      // Track CR LF CR LF.
      if (in_byte_q == ChCr) begin
        term_d = (term_cur == 2'd2) ? 2'd3 : 2'd1;
      end else if (in_byte_q == ChLf) begin
        done   = (term_cur == 2'd3);
        term_d = (term_cur == 2'd1) ? 2'd2 : 2'd0;
      end else begin
        term_d = 2'd0;
      end
      count = cnt_cur + CntW'(1);
      if (done) begin
        last_d  = 1'b1;
        phase_d = PhBoundary;
        rcnt_d  = '0;
        term_d  = 2'd0;
      end else if (count >= limit_q) begin
        // Cut the request at the limit and flag it.
        last_d  = 1'b1;
        ovf_d   = 1'b1;
        phase_d = PhBoundary;
        rcnt_d  = '0;
        term_d  = 2'd0;
      end else begin
        rcnt_d  = count;
        phase_d = PhRequest;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhBoundary;
      hidx_q   <= 2'd0;
      chan_q   <= 8'd0;
      flen_q   <= 16'd0;
      remain_q <= 16'd0;
      term_q   <= 2'd0;
      rcnt_q   <= '0;
    end else if (step) begin
      phase_q  <= phase_d;
      hidx_q   <= hidx_d;
      chan_q   <= chan_d;
      flen_q   <= flen_d;
      remain_q <= remain_d;
      term_q   <= term_d;
      rcnt_q   <= rcnt_d;
    end
  end

  // Result register: load on advance, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_o       <= in_byte_q;
      unit_kind_o      <= kind_d;
      channel_o        <= ochan_d;
      payload_length_o <= oplen_d;
      unit_first_o     <= first_d;
      unit_last_o      <= last_d;
      overflow_o       <= ovf_d;
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_rtsp_interleaved_stream_splitter.sv
`timescale 1ns / 1ps
// Self-checking bench for the RTSP interleaved stream splitter: drives a byte
// stream of frames and text requests and checks every tagged output byte
// against a cycle-free model of the splitter. Depends on riss_pkg and the RTL.
module tb_rtsp_interleaved_stream_splitter;
  import riss_pkg::*;

  localparam int unsigned BUF_BYTES   = 2097152;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int          PHASE_BYTES = 220;

  // One predicted output transfer
  typedef struct packed {
    logic [7:0]  b;
    unit_kind_e  kind;
    logic [7:0]  chan;
    logic [15:0] len;
    logic        first;
    logic        last;
    logic        ovf;
  } split_byte_t;

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic              cfg_idx_i    = CfgMagic;
  logic [LimitW-1:0] cfg_wdata_i  = '0;
  logic              data_valid_i = 1'b0;
  logic [7:0]        data_byte_i  = '0;
  logic              out_stall_i  = 1'b0;
  logic              data_stall_o;
  logic              out_valid_o;
  logic [7:0]        out_byte_o;
  logic [1:0]        unit_kind_o;
  logic [7:0]        channel_o;
  logic [15:0]       payload_length_o;
  logic              unit_first_o;
  logic              unit_last_o;
  logic              overflow_o;

  rtsp_interleaved_stream_splitter #(
    .REQUEST_BUFFER_BYTES(BUF_BYTES)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .data_valid_i    (data_valid_i),
    .data_stall_o    (data_stall_o),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .unit_kind_o     (unit_kind_o),
    .channel_o       (channel_o),
    .payload_length_o(payload_length_o),
    .unit_first_o    (unit_first_o),
    .unit_last_o     (unit_last_o),
    .overflow_o      (overflow_o)
  );

  // Bytes waiting to be sent, tags predicted for sent bytes, and the count of
  // bytes queued or in the block whose tag has not been checked yet.
  logic [7:0]  pending_bytes [$];
  split_byte_t predicted_tags [$];
  int          bytes_in_flight = 0;
  int          fail_count      = 0;
  int          cycle_count     = 0;
  int          idle_pct        = 35;
  int          stall_pct       = 35;

  // Splitter model state and its copy of the configuration
  logic [7:0]        cfg_magic;
  logic [LimitW-1:0] cfg_limit;
  phase_e            ph;
  logic [1:0]        hdr_idx;
  logic [7:0]        fr_chan;
  logic [15:0]       fr_len;
  logic [15:0]       remaining;
  logic [1:0]        term_match;
  logic [LimitW-1:0] req_count;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Advance the model by one byte and return the tag it must carry.
  function automatic split_byte_t split_byte(logic [7:0] b);
    split_byte_t res;
    logic        text;
    logic        done;
    int unsigned lim;
    int unsigned count;
    res   = '0;
    res.b = b;
    text  = 1'b0;
    done  = 1'b0;
    case (ph)
      PhBoundary: begin
        res.first = 1'b1;
        if (b == cfg_magic) begin
          res.kind = KindHeader;
          fr_chan  = '0;
          fr_len   = '0;
          hdr_idx  = 2'd1;
          ph       = PhHeader;
        end else begin
          req_count  = '0;
          term_match = '0;
          text       = 1'b1;
        end
      end
      PhHeader: begin
        res.kind = KindHeader;
        case (hdr_idx)
          2'd1:    fr_chan = b;
          2'd2:    fr_len = {b, 8'h00};
          default: fr_len[7:0] = b;
        endcase
        res.chan = fr_chan;
        if (hdr_idx == 2'd3 || hdr_idx == 2'd0) begin
          res.len = fr_len;
          hdr_idx = '0;
          // a zero length frame ends on its last header byte
          if (fr_len == '0) begin
            res.last = 1'b1;
            ph       = PhBoundary;
          end else begin
            remaining = fr_len;
            ph        = PhPayload;
          end
        end else begin
          hdr_idx = hdr_idx + 2'd1;
        end
      end
      PhPayload: begin
        res.kind  = KindPayload;
        res.chan  = fr_chan;
        res.len   = fr_len;
        remaining = remaining - 16'd1;
        if (remaining == '0) begin
          res.last = 1'b1;
          ph       = PhBoundary;
        end
      end
      default: text = 1'b1;
    endcase

    if (text) begin
      res.kind = KindText;
      // track CR LF CR LF; a CR after CR LF moves to the third step
      if (b == ChCr) begin
        term_match = (term_match == 2'd2) ? 2'd3 : 2'd1;
      end else if (b == ChLf) begin
        done       = (term_match == 2'd3);
        term_match = (term_match == 2'd1) ? 2'd2 : 2'd0;
      end else begin
        term_match = '0;
      end
      lim = 32'(cfg_limit);
      if (lim > BUF_BYTES) lim = BUF_BYTES;
      if (lim < LimitMin) lim = LimitMin;
      count = req_count + 1;
      // the terminator wins when it lands on the limit byte
      if (done || count >= lim) begin
        res.last   = 1'b1;
        res.ovf    = !done;
        ph         = PhBoundary;
        req_count  = '0;
        term_match = '0;
      end else begin
        req_count = LimitW'(count);
        ph        = PhRequest;
      end
    end
    return res;
  endfunction

  function automatic void send(logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_in_flight++;
  endfunction

  // Queue one unit with random content; return the number of bytes queued.
  function automatic int add_unit();
    int unsigned r;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  b;
    r = $urandom_range(99);
    if (r < 40) begin
      // interleaved frame, mostly short, now and then a long one
      len = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(12);
      send(cfg_magic);
      send(8'($urandom_range(255)));
      send(len[15:8]);
      send(len[7:0]);
      for (int i = 0; i < len; i++) send(8'($urandom_range(255)));
      return len + 4;
    end
    // text request; keep the opening byte off the magic value
    len = $urandom_range(1, 24);
    do b = 8'($urandom_range(255)); while (b == cfg_magic);
    send(b);
    for (int i = 1; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 70)      b = 8'($urandom_range(32, 126));
      else if (pick < 80) b = ChCr;
      else if (pick < 90) b = ChLf;
      else                b = 8'($urandom_range(255));
      send(b);
    end
    // most requests end properly; the rest run into whatever follows
    if (r < 85) begin
      send(ChCr);
      send(ChLf);
      send(ChCr);
      send(ChLf);
      len += 4;
    end
    return len;
  endfunction

  // Hold until every queued byte has come back out and been checked.
  task automatic wait_idle();
    while (bytes_in_flight != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [LimitW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMagic) cfg_magic = value[7:0];
    else cfg_limit = value;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Sender: predict each byte as it transfers, then offer the next one or
  // idle at random. A stalled byte is held untouched.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (data_valid_i && !data_stall_o) predicted_tags.push_back(split_byte(data_byte_i));
      if (!data_valid_i || !data_stall_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          data_valid_i <= 1'b1;
          data_byte_i  <= pending_bytes.pop_front();
        end else begin
          data_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each output transfer against the oldest prediction and
  // stall at random.
  always @(posedge clk_i) begin
    split_byte_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_tags.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual byte %0h",
                   $time, out_byte_o);
          fail_count++;
        end else begin
          want = predicted_tags.pop_front();
          bytes_in_flight--;
          check_field("out_byte", want.b, out_byte_o);
          check_field("unit_kind", want.kind, unit_kind_o);
          check_field("channel", want.chan, channel_o);
          check_field("payload_length", want.len, payload_length_o);
          check_field("unit_first", want.first, unit_first_o);
          check_field("unit_last", want.last, unit_last_o);
          check_field("overflow", want.ovf, overflow_o);
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rtsp_interleaved_stream_splitter verification failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]        opening [21];
    logic [7:0]        cut_tail [5];
    logic [7:0]        next_magic;
    logic [LimitW-1:0] next_limit;
    int                added;

    // zero length frame, a frame whose payload holds the magic value, a text
    // request opened by a zero byte with CR CR LF CR LF, and a request left
    // open at five bytes
    opening = '{MagicReset, 8'hFF, 8'h00, 8'h00,
                MagicReset, 8'h00, 8'h00, 8'h02, MagicReset, 8'hFF,
                8'h00, ChCr, ChCr, ChLf, ChCr, ChLf,
                8'h47, 8'h45, 8'h54, 8'h80, 8'h7F};
    // first byte cuts the open request at the new limit, then a request whose
    // terminator lands exactly on the limit byte
    cut_tail = '{8'h20, ChCr, ChLf, ChCr, ChLf};

    cfg_magic  = MagicReset;
    cfg_limit  = LimitW'(LimitReset);
    ph         = PhBoundary;
    hdr_idx    = '0;
    fr_chan    = '0;
    fr_len     = '0;
    remaining  = '0;
    term_match = '0;
    req_count  = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening[i]) send(opening[i]);
    wait_idle();
    // drop the limit below what the open request already holds; zero clamps to
    // the minimum
    write_reg(CfgLimit, '0);
    foreach (cut_tail[i]) send(cut_tail[i]);

    for (int p = 0; p < 5; p++) begin
      // open a short frame and leave its last payload byte for the next setting
      send(cfg_magic);
      send(8'h5A);
      send(8'h00);
      send(8'h02);
      send(8'($urandom_range(255)));
      wait_idle();
      case (p)
        0: begin
          next_magic = 8'hFF;
          next_limit = '1;
        end
        1: begin
          next_magic = 8'h00;
          next_limit = 22'd6;
        end
        2: begin
          next_magic = MagicReset;
          next_limit = LimitW'(LimitMin);
        end
        3: begin
          next_magic = 8'($urandom_range(255));
          next_limit = LimitW'($urandom_range(5, 40));
        end
        default: begin
          next_magic = ChCr;
          next_limit = LimitW'($urandom);
        end
      endcase
      write_reg(CfgMagic, LimitW'(next_magic));
      write_reg(CfgLimit, next_limit);
      // run the first setting without any gaps on either side
      idle_pct  = (p == 0) ? 0 : 35;
      stall_pct = (p == 0) ? 0 : 35;
      // the new magic value lands inside the open frame and stays payload
      send(next_magic);
      added = 1;
      while (added < PHASE_BYTES / 2) added += add_unit();
      // let the sender run dry once in mid-stream
      if (p == 2) wait_idle();
      while (added < PHASE_BYTES) added += add_unit();
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("rtsp_interleaved_stream_splitter verification clean");
    end else begin
      $display("rtsp_interleaved_stream_splitter verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/riss_pkg.sv
hw/rtl/rtsp_interleaved_stream_splitter.sv
tb/tb_rtsp_interleaved_stream_splitter.sv
